// ===== hdl/rmos_pkg.sv =====
// Package for the rational model output simulator: sizes, operation and
// structure codes, configuration and command types shared by all modules.
// No dependencies.
package rmos_pkg;

    localparam int MAX_ORDER  = 8;
    localparam int MAX_DELAY  = 16;
    localparam int COEF_DEPTH = 32;
    localparam int IN_DEPTH   = MAX_DELAY + MAX_ORDER;

    localparam int DATA_W    = 24;
    localparam int FRAC_BITS = 20;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(2 * MAX_ORDER) + 1;

    localparam int COEF_AW = $clog2(COEF_DEPTH);
    localparam int IN_AW   = $clog2(IN_DEPTH);
    localparam int OUT_AW  = $clog2(MAX_ORDER);
    localparam int ORD_W   = $clog2(MAX_ORDER + 1);
    localparam int DLY_W   = $clog2(MAX_DELAY + 2);
    localparam int STEP_W  = $clog2(2 * MAX_ORDER + 1);
    localparam int IDX_W   = $clog2(4 * MAX_ORDER + 1);

    localparam int Y_MAX = 8388607;
    localparam int Y_MIN = -8388608;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // request operations
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_PAST   = 2'd2;
    localparam logic [1:0] OP_SAMPLE = 2'd3;

    // model structures
    localparam logic [2:0] MS_ARX   = 3'd0;
    localparam logic [2:0] MS_ARMAX = 3'd1;
    localparam logic [2:0] MS_OE    = 3'd2;
    localparam logic [2:0] MS_BJ    = 3'd3;
    localparam logic [2:0] MS_FIR   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRUCT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ORDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C_ORDER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_D_ORDER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_F_ORDER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd6;

    localparam logic [4:0] DELAY_RESET = 5'd1;

    typedef struct packed {
        logic [2:0] model_structure;
        logic [3:0] den_a_order;
        logic [3:0] num_b_order;
        logic [3:0] noise_c_order;
        logic [3:0] noise_d_order;
        logic [3:0] den_f_order;
        logic [4:0] input_delay;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     clr;
        logic                     shift_in;
        logic                     wr_out;
        logic                     push_out;
        logic [OUT_AW-1:0]        out_slot;
        logic signed [DATA_W-1:0] value;
    } t_hist_cmd;

    typedef struct packed {
        logic                     clr;
        logic                     rnd;
        logic                     v;
        logic                     sub;
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] opnd;
    } t_mac_cmd;

    typedef struct packed {
        logic                     busy;
        logic                     sat;
        logic signed [DATA_W-1:0] y;
    } t_mac_stat;

    function automatic logic [ORD_W-1:0] clamp_order(input logic [3:0] n);
        if (int'(n) > MAX_ORDER) begin
            return ORD_W'(MAX_ORDER);
        end
        return ORD_W'(n);
    endfunction

endpackage

// ===== hdl/rmos_in_if.sv =====
// Request channel of the rational model output simulator.
// Depends on rmos_pkg for the field widths.
interface rmos_in_if;
    import rmos_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic [4:0]               slot;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output slot, output value, input ready);
    modport sink   (input valid, input operation, input slot, input value, output ready);
    modport mon    (input valid, input operation, input slot, input value, input ready);
endinterface

// ===== hdl/rmos_out_if.sv =====
// Result channel of the rational model output simulator.
// Depends on rmos_pkg for the field widths.
interface rmos_out_if;
    import rmos_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sim_output;
    logic                     saturated;
    logic                     bad_structure;

    modport source (output valid, output sim_output, output saturated, output bad_structure,
                    input ready);
    modport sink   (input valid, input sim_output, input saturated, input bad_structure,
                    output ready);
    modport mon    (input valid, input sim_output, input saturated, input bad_structure,
                    input ready);
endinterface

// ===== hdl/rational_model_output_simulator.sv =====
// A sample request walks nb + nden taps, where nb and nden are the clamped orders (no tap
// is walked when both are zero, as for an unsupported structure), then drains, rounds and
// loads the result register; other requests are taken in the idle state. One sample at a time:
// the shared multiply-accumulate walks one tap per cycle, and a sample occupies the block until
// its result is loaded, longer while the previous result waits to be taken.
// Synchronous active-low reset clears control, histories and configuration (delay to 1).
module rational_model_output_simulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rmos_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rmos_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rmos_in_if.sink                             i_in,
    rmos_out_if.source                          o_out
);
    import rmos_pkg::*;

    t_cfg      r_cfg;
    t_hist_cmd w_hist;
    t_mac_cmd  w_mac_cmd;
    t_mac_stat w_mac_stat;
    logic [IN_AW-1:0]         w_age;
    logic [OUT_AW-1:0]        w_oidx;
    logic signed [DATA_W-1:0] w_in_tap, w_out_tap;
    logic w_load, w_bad, w_out_free;

    logic                     r_out_v;
    logic signed [DATA_W-1:0] r_y;
    logic                     r_sat;
    logic                     r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{input_delay: DELAY_RESET, default: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STRUCT:  r_cfg.model_structure <= i_cfg_data[2:0];
                REG_A_ORDER: r_cfg.den_a_order     <= i_cfg_data[3:0];
                REG_B_ORDER: r_cfg.num_b_order     <= i_cfg_data[3:0];
                REG_C_ORDER: r_cfg.noise_c_order   <= i_cfg_data[3:0];
                REG_D_ORDER: r_cfg.noise_d_order   <= i_cfg_data[3:0];
                REG_F_ORDER: r_cfg.den_f_order     <= i_cfg_data[3:0];
                REG_DELAY:   r_cfg.input_delay     <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    rmos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in       (i_in),
        .i_in_tap   (w_in_tap),
        .i_out_tap  (w_out_tap),
        .i_mac      (w_mac_stat),
        .i_out_free (w_out_free),
        .o_hist     (w_hist),
        .o_age      (w_age),
        .o_oidx     (w_oidx),
        .o_mac      (w_mac_cmd),
        .o_load     (w_load),
        .o_bad      (w_bad)
    );

    rmos_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_hist),
        .i_age     (w_age),
        .i_oidx    (w_oidx),
        .o_in_tap  (w_in_tap),
        .o_out_tap (w_out_tap)
    );

    rmos_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mac_cmd),
        .o_stat  (w_mac_stat)
    );

    // result register: hold until taken
    assign w_out_free = !r_out_v || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_y   <= w_mac_stat.y;
            r_sat <= w_mac_stat.sat;
            r_bad <= w_bad;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.sim_output    = r_y;
    assign o_out.saturated     = r_sat;
    assign o_out.bad_structure = r_bad;
endmodule

// ===== hdl/rmos_hist.sv =====
// Input and output sample histories: shift lines with tap read ports.
// Depends on rmos_pkg.
module rmos_hist (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rmos_pkg::t_hist_cmd       i_cmd,
    input  logic [rmos_pkg::IN_AW-1:0]  i_age,
    input  logic [rmos_pkg::OUT_AW-1:0] i_oidx,
    output logic signed [rmos_pkg::DATA_W-1:0] o_in_tap,
    output logic signed [rmos_pkg::DATA_W-1:0] o_out_tap
);
    import rmos_pkg::*;

    logic signed [DATA_W-1:0] r_in_hist  [IN_DEPTH];
    logic signed [DATA_W-1:0] r_out_hist [MAX_ORDER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            for (int k = 0; k < IN_DEPTH; k++) begin
                r_in_hist[k] <= '0;
            end
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_out_hist[k] <= '0;
            end
        end else begin
            if (i_cmd.shift_in) begin
                for (int k = IN_DEPTH - 1; k > 0; k--) begin
                    r_in_hist[k] <= r_in_hist[k-1];
                end
                r_in_hist[0] <= i_cmd.value;
            end
            if (i_cmd.wr_out) begin
                r_out_hist[i_cmd.out_slot] <= i_cmd.value;
            end else if (i_cmd.push_out) begin
                for (int k = MAX_ORDER - 1; k > 0; k--) begin
                    r_out_hist[k] <= r_out_hist[k-1];
                end
                r_out_hist[0] <= i_cmd.value;
            end
        end
    end

    assign o_in_tap  = r_in_hist[i_age];
    assign o_out_tap = r_out_hist[i_oidx];
endmodule

// ===== hdl/rmos_mac.sv =====
// Shared multiply-accumulate unit with rounding and 24-bit saturation.
// Depends on rmos_pkg.
module rmos_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rmos_pkg::t_mac_cmd  i_cmd,
    output rmos_pkg::t_mac_stat o_stat
);
    import rmos_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] ACC_YMAX = ACC_W'(Y_MAX);
    localparam logic signed [ACC_W-1:0] ACC_YMIN = ACC_W'(Y_MIN);

    logic                     r_prod_v;
    logic                     r_prod_sub;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_y;
    logic                     r_sat;

    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_shr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_cmd.v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= i_cmd.coef * i_cmd.opnd;
        r_prod_sub <= i_cmd.sub;
        if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            if (r_prod_sub) begin
                r_acc <= r_acc - ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // round half up, then floor to an integer
    always_comb begin
        w_sum = r_acc + RND_HALF;
        w_shr = w_sum >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd) begin
            if (w_shr > ACC_YMAX) begin
                r_y   <= DATA_W'(Y_MAX);
                r_sat <= 1'b1;
            end else if (w_shr < ACC_YMIN) begin
                r_y   <= DATA_W'(Y_MIN);
                r_sat <= 1'b1;
            end else begin
                r_y   <= w_shr[DATA_W-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_prod_v;
    assign o_stat.sat  = r_sat;
    assign o_stat.y    = r_y;
endmodule

// ===== hdl/rmos_ctrl.sv =====
// Sequencer: request decode, coefficient store, tap walk feeding the shared
// multiply-accumulate unit. Depends on rmos_pkg and rmos_in_if.
module rmos_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rmos_pkg::t_cfg             i_cfg,
    rmos_in_if.sink                    i_in,
    input  logic signed [rmos_pkg::DATA_W-1:0] i_in_tap,
    input  logic signed [rmos_pkg::DATA_W-1:0] i_out_tap,
    input  rmos_pkg::t_mac_stat        i_mac,
    input  logic                       i_out_free,
    output rmos_pkg::t_hist_cmd        o_hist,
    output logic [rmos_pkg::IN_AW-1:0]  o_age,
    output logic [rmos_pkg::OUT_AW-1:0] o_oidx,
    output rmos_pkg::t_mac_cmd         o_mac,
    output logic                       o_load,
    output logic                       o_bad
);
    import rmos_pkg::*;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic r_bad;
    logic r_iss_v;
    logic r_iss_sub;
    logic r_cz;
    logic signed [DATA_W-1:0] r_opnd;
    logic signed [DATA_W-1:0] r_coef_q;
    logic signed [DATA_W-1:0] r_coef_mem [COEF_DEPTH];

    logic [ORD_W-1:0]  w_nb, w_nden;
    logic [DLY_W-1:0]  w_nk;
    logic [IDX_W-1:0]  w_b_off, w_den_off, w_cidx;
    logic [STEP_W-1:0] w_total, w_dstep;
    logic w_bad, w_in_b, w_last, w_acc, w_sample;

    // decode the coefficient packing from the structure
    always_comb begin
        w_nb    = clamp_order(i_cfg.num_b_order);
        w_nk    = (int'(i_cfg.input_delay) > MAX_DELAY) ? DLY_W'(MAX_DELAY)
                                                       : DLY_W'(i_cfg.input_delay);
        w_bad     = 1'b0;
        w_nden    = '0;
        w_b_off   = '0;
        w_den_off = '0;
        case (i_cfg.model_structure)
            MS_ARX, MS_ARMAX: begin
                w_nden  = clamp_order(i_cfg.den_a_order);
                w_b_off = IDX_W'(w_nden);
            end
            MS_OE: begin
                w_nden    = clamp_order(i_cfg.den_f_order);
                w_den_off = IDX_W'(w_nb);
            end
            MS_BJ: begin
                w_nden    = clamp_order(i_cfg.den_f_order);
                w_den_off = IDX_W'(w_nb) + IDX_W'(clamp_order(i_cfg.noise_c_order))
                          + IDX_W'(clamp_order(i_cfg.noise_d_order));
            end
            MS_FIR: begin
                w_nden = '0;
            end
            default: begin
                w_bad = 1'b1;
                w_nb  = '0;
            end
        endcase
        w_total = STEP_W'(w_nb) + STEP_W'(w_nden);
        w_in_b  = r_step < STEP_W'(w_nb);
        w_dstep = r_step - STEP_W'(w_nb);
        w_cidx  = w_in_b ? (w_b_off + IDX_W'(r_step)) : (w_den_off + IDX_W'(w_dstep));
        w_last  = (r_step == w_total - STEP_W'(1));
    end

    assign w_acc    = i_in.valid && i_in.ready;
    assign w_sample = w_acc && (i_in.operation == OP_SAMPLE);

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (w_sample) begin
                    n_state = (w_total == '0) ? ST_DRAIN : ST_MAC;
                end
            end
            ST_MAC: begin
                n_step = r_step + STEP_W'(1);
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_iss_v && !i_mac.busy) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready      = (r_state == ST_IDLE);
        o_hist.clr      = w_acc && (i_in.operation == OP_START);
        o_hist.shift_in = w_sample;
        o_hist.wr_out   = w_acc && (i_in.operation == OP_PAST) && (int'(i_in.slot) < MAX_ORDER);
        o_hist.push_out = (r_state == ST_DONE) && i_out_free;
        o_hist.out_slot = OUT_AW'(i_in.slot);
        o_hist.value    = (r_state == ST_DONE) ? i_mac.y : i_in.value;
        o_age           = IN_AW'(w_nk) + IN_AW'(r_step);
        o_oidx          = OUT_AW'(w_dstep);
        o_mac.clr       = w_sample;
        o_mac.rnd       = (r_state == ST_ROUND);
        o_mac.v         = r_iss_v;
        o_mac.sub       = r_iss_sub;
        o_mac.coef      = r_cz ? '0 : r_coef_q;
        o_mac.opnd      = r_opnd;
        o_load          = (r_state == ST_DONE) && i_out_free;
        o_bad           = r_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_iss_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_iss_v <= (r_state == ST_MAC);
        end
    end

    // issue stage: operand and flags alongside the store read
    always_ff @(posedge i_clk) begin
        r_iss_sub <= !w_in_b;
        r_opnd    <= w_in_b ? i_in_tap : i_out_tap;
        r_cz      <= (int'(w_cidx) >= COEF_DEPTH);
        if (w_sample) begin
            r_bad <= w_bad;
        end
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_in.operation == OP_COEF) && (int'(i_in.slot) < COEF_DEPTH)) begin
            r_coef_mem[COEF_AW'(i_in.slot)] <= i_in.value;
        end
        r_coef_q <= r_coef_mem[COEF_AW'(w_cidx)];
    end
endmodule

// ===== hdl/rmos_chk.sv =====
// Port-level checks for the rational model output simulator, bound to the top level.
// Depends on rmos_pkg, rmos_in_if and rmos_out_if.
module rmos_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    rmos_in_if.sink    i_in,
    rmos_out_if.source i_out
);
    import rmos_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && !i_out.ready |=> i_out.valid)
        else $error("result dropped before it was taken");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && i_out.bad_structure |-> (i_out.sim_output == '0) && !i_out.saturated)
        else $error("unsupported structure gave a nonzero result");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && i_out.saturated |->
            (i_out.sim_output == DATA_W'(Y_MAX)) || (i_out.sim_output == DATA_W'(Y_MIN)))
        else $error("clipped result is not at a limit");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (i_in.operation == OP_SAMPLE) |=> !i_in.ready)
        else $error("request taken while a sample is in progress");
endmodule

bind rational_model_output_simulator rmos_chk u_rmos_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .i_out   (o_out)
);
